// ===== rtl/core/nga_pkg.sv =====
// shared types, constants and helpers for the nearest grid velocity advect unit
package nga_pkg;

	// grid size per axis
	localparam int GRID_X = 16;
	localparam int GRID_Y = 16;
	localparam int GRID_Z = 16;

	localparam int IDX_W    = 8;
	localparam int ADDR_W   = 12;
	localparam int DEPTH    = 1 << ADDR_W;
	localparam int LANE_LAT = 12;
	localparam int CFG_IDX_W = 3;

	// transaction modes
	localparam logic MODE_LOAD   = 1'b0;
	localparam logic MODE_ADVECT = 1'b1;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_X_LOW     = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_X_HIGH    = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_Y_LOW     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_Y_HIGH    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_Z_LOW     = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_Z_HIGH    = 3'd6;

	localparam logic [30:0] TIME_STEP_RST = 31'd65536;
	localparam logic signed [31:0] LOW_RST  = 32'sd0;
	localparam logic signed [31:0] HIGH_RST = 32'sd65536;

	typedef struct packed {
		logic              mode;
		logic [11:0]       voxel_index;
		logic signed [31:0] load_vel_x;
		logic signed [31:0] load_vel_y;
		logic signed [31:0] load_vel_z;
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] pos_z;
	} in_item_t;

	typedef struct packed {
		logic signed [31:0] new_pos_x;
		logic signed [31:0] new_pos_y;
		logic signed [31:0] new_pos_z;
		logic signed [31:0] used_vel_x;
		logic signed [31:0] used_vel_y;
		logic signed [31:0] used_vel_z;
	} out_item_t;

	typedef struct packed {
		logic signed [31:0] vx;
		logic signed [31:0] vy;
		logic signed [31:0] vz;
	} vel_t;

	// linear voxel address, x fastest, wrapped to the store
	function automatic logic [ADDR_W-1:0] grid_addr(input logic [IDX_W-1:0] i,
			input logic [IDX_W-1:0] j, input logic [IDX_W-1:0] k);
		logic [31:0] t;
		t = 32'(i) + 32'(GRID_X) * (32'(j) + 32'(GRID_Y) * 32'(k));
		return t[ADDR_W-1:0];
	endfunction

endpackage

// ===== rtl/core/nga_axis_lane.sv =====
// one axis: normalize position against bounds and find nearest grid index
module nga_axis_lane import nga_pkg::*; (
	input  logic                    clk,
	input  logic                    en,
	input  logic signed [31:0]      pos,
	input  logic signed [31:0]      lo,
	input  logic signed [31:0]      hi,
	input  logic [IDX_W-1:0]        nm1,
	output logic [IDX_W-1:0]        idx
);

	localparam int REM_W = 44;
	localparam int D_W   = 35;

	logic signed [32:0] diff_s1, den_s1;
	logic signed [41:0] num_c;
	logic [41:0]        an_s2;
	logic [32:0]        ad_s2;
	logic               neg_s2, zero_s2;
	logic [REM_W-1:0]   n_c, dsh_c;

	// divider stages: entry 0 is stage 3, entry 8 is stage 11
	logic [REM_W-1:0]   rem_s [0:IDX_W];
	logic [D_W-1:0]     dd_s  [0:IDX_W];
	logic [IDX_W-1:0]   q_s   [0:IDX_W];
	logic               neg_s [0:IDX_W];
	logic               zero_s[0:IDX_W];
	logic               ovf_s [0:IDX_W];
	logic [REM_W:0]     trial [0:IDX_W-1];
	logic [IDX_W-1:0]   idx_s12;

	// offset from low bound and span
	always_ff @(posedge clk) begin
		if (en) begin
			diff_s1 <= 33'(pos) - 33'(lo);
			den_s1  <= 33'(hi) - 33'(lo);
		end
	end

	// scale by grid size minus one, split into sign and magnitude
	assign num_c = diff_s1 * $signed({1'b0, nm1});
	always_ff @(posedge clk) begin
		if (en) begin
			an_s2   <= num_c[41] ? 42'(-num_c) : 42'(num_c);
			ad_s2   <= den_s1[32] ? 33'(-den_s1) : 33'(den_s1);
			neg_s2  <= num_c[41] != den_s1[32];
			zero_s2 <= den_s1 == 33'sd0;
		end
	end

	// rounding numerator and doubled divisor, quotient overflow check
	assign n_c   = {an_s2, 1'b0} + 44'(ad_s2);
	assign dsh_c = 44'({ad_s2, 1'b0}) << IDX_W;

	// restoring division trial subtracts
	always_comb begin
		for (int t = 0; t < IDX_W; t++) begin
			trial[t] = {1'b0, rem_s[t]} - {1'b0, 44'(dd_s[t]) << (IDX_W - 1 - t)};
		end
	end

	// divider entry stage, then one quotient bit per stage
	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0]  <= n_c;
			dd_s[0]   <= D_W'({ad_s2, 1'b0});
			q_s[0]    <= '0;
			neg_s[0]  <= neg_s2;
			zero_s[0] <= zero_s2;
			ovf_s[0]  <= n_c >= dsh_c;
			for (int t = 0; t < IDX_W; t++) begin
				rem_s[t+1]  <= trial[t][REM_W] ? rem_s[t] : trial[t][REM_W-1:0];
				q_s[t+1]    <= {q_s[t][IDX_W-2:0], ~trial[t][REM_W]};
				dd_s[t+1]   <= dd_s[t];
				neg_s[t+1]  <= neg_s[t];
				zero_s[t+1] <= zero_s[t];
				ovf_s[t+1]  <= ovf_s[t];
			end
		end
	end

	// equal bounds or negative quotient give zero, else clamp to the grid
	always_ff @(posedge clk) begin
		if (en) begin
			if (zero_s[IDX_W] || neg_s[IDX_W])
				idx_s12 <= '0;
			else if (ovf_s[IDX_W] || q_s[IDX_W] > nm1)
				idx_s12 <= nm1;
			else
				idx_s12 <= q_s[IDX_W];
		end
	end

	assign idx = idx_s12;

endmodule

// ===== rtl/core/nga_advance_lane.sv =====
// one axis: position plus rounded velocity times step, saturated
module nga_advance_lane import nga_pkg::*; (
	input  logic               clk,
	input  logic               en,
	input  logic signed [31:0] pos,
	input  logic signed [31:0] vel,
	input  logic [30:0]        step,
	output logic signed [31:0] new_pos
);

	logic [31:0]        vmag_c;
	logic [62:0]        mag_s1;
	logic               neg_s1;
	logic signed [31:0] pos_s1;
	logic [46:0]        d_c;
	logic signed [48:0] sum_c;
	logic signed [31:0] new_pos_s2;

	// magnitude product
	assign vmag_c = vel[31] ? 32'(-vel) : 32'(vel);
	always_ff @(posedge clk) begin
		if (en) begin
			mag_s1 <= 63'(vmag_c) * 63'(step);
			neg_s1 <= vel[31];
			pos_s1 <= pos;
		end
	end

	// round to q16.16 and saturating add
	assign d_c   = 47'((64'(mag_s1) + 64'd32768) >> 16);
	assign sum_c = neg_s1 ? 49'(pos_s1) - 49'($signed({1'b0, d_c}))
	                      : 49'(pos_s1) + 49'($signed({1'b0, d_c}));
	always_ff @(posedge clk) begin
		if (en) begin
			if (sum_c > 49'sd2147483647)
				new_pos_s2 <= 32'sh7fffffff;
			else if (sum_c < -49'sd2147483648)
				new_pos_s2 <= 32'sh80000000;
			else
				new_pos_s2 <= sum_c[31:0];
		end
	end

	assign new_pos = new_pos_s2;

endmodule

// ===== rtl/core/nearest_grid_velocity_advect_unit.sv =====
// Top level: pipelined, one transaction per cycle when out_stall is low.
// Lanes: per-axis index search (restoring divider, one bit a stage), then
// address merge, grid memory access, and multiply and add stages.
// Loads write the grid at the memory stage in transaction order and give no result.
// arst_n clears pipeline valids and resets the configuration registers; grid
// contents are undefined until written and have no clearing pass.
module nearest_grid_velocity_advect_unit import nga_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_stall,
	input  in_item_t             in_data,
	output logic                 out_valid,
	input  logic                 out_stall,
	output out_item_t            out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	logic [30:0]        time_step_q;
	logic signed [31:0] lo_q [0:2];
	logic signed [31:0] hi_q [0:2];

	logic               en;
	logic               vld_s [1:LANE_LAT];
	in_item_t           sb_s  [1:LANE_LAT];
	logic [IDX_W-1:0]   idx_c [0:2];
	logic [IDX_W-1:0]   nm1_c [0:2];

	logic               v_s13, v_s14, v_s15, v_s16;
	logic               adv_s13, adv_s14, adv_s15, adv_s16;
	in_item_t           item_s13;
	logic [ADDR_W-1:0]  addr_s13;
	logic [IDX_W-1:0]   i_s13, j_s13, k_s13;
	vel_t               rd_s14, vel_s15, vel_s16;
	logic signed [31:0] pos_s14 [0:2];
	logic signed [31:0] np_c [0:2];
	vel_t               grid_mem [0:DEPTH-1];

	// advance whenever the output register can move
	assign en        = !(out_valid && out_stall);
	assign in_stall  = !en;
	assign cfg_ready = 1'b1;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			time_step_q <= TIME_STEP_RST;
			for (int a = 0; a < 3; a++) begin
				lo_q[a] <= LOW_RST;
				hi_q[a] <= HIGH_RST;
			end
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_TIME_STEP: time_step_q <= cfg_data[30:0];
				REG_X_LOW:     lo_q[0] <= cfg_data;
				REG_X_HIGH:    hi_q[0] <= cfg_data;
				REG_Y_LOW:     lo_q[1] <= cfg_data;
				REG_Y_HIGH:    hi_q[1] <= cfg_data;
				REG_Z_LOW:     lo_q[2] <= cfg_data;
				REG_Z_HIGH:    hi_q[2] <= cfg_data;
				default: ;
			endcase
		end
	end

	// per-axis index lanes
	assign nm1_c[0] = IDX_W'(GRID_X - 1);
	assign nm1_c[1] = IDX_W'(GRID_Y - 1);
	assign nm1_c[2] = IDX_W'(GRID_Z - 1);

	nga_axis_lane u_axis_x (.clk, .en, .pos(in_data.pos_x), .lo(lo_q[0]), .hi(hi_q[0]),
		.nm1(nm1_c[0]), .idx(idx_c[0]));
	nga_axis_lane u_axis_y (.clk, .en, .pos(in_data.pos_y), .lo(lo_q[1]), .hi(hi_q[1]),
		.nm1(nm1_c[1]), .idx(idx_c[1]));
	nga_axis_lane u_axis_z (.clk, .en, .pos(in_data.pos_z), .lo(lo_q[2]), .hi(hi_q[2]),
		.nm1(nm1_c[2]), .idx(idx_c[2]));

	// sideband line alongside the lanes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int s = 1; s <= LANE_LAT; s++)
				vld_s[s] <= 1'b0;
			v_s13 <= 1'b0;
			v_s14 <= 1'b0;
			v_s15 <= 1'b0;
			v_s16 <= 1'b0;
		end else if (en) begin
			vld_s[1] <= in_valid;
			for (int s = 2; s <= LANE_LAT; s++)
				vld_s[s] <= vld_s[s-1];
			v_s13 <= vld_s[LANE_LAT];
			v_s14 <= v_s13;
			v_s15 <= v_s14;
			v_s16 <= v_s15;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sb_s[1] <= in_data;
			for (int s = 2; s <= LANE_LAT; s++)
				sb_s[s] <= sb_s[s-1];
		end
	end

	// merge lane indexes into one grid address
	always_ff @(posedge clk) begin
		if (en) begin
			item_s13 <= sb_s[LANE_LAT];
			adv_s13  <= sb_s[LANE_LAT].mode == MODE_ADVECT;
			i_s13    <= idx_c[0];
			j_s13    <= idx_c[1];
			k_s13    <= idx_c[2];
			addr_s13 <= (sb_s[LANE_LAT].mode == MODE_ADVECT)
				? grid_addr(idx_c[0], idx_c[1], idx_c[2])
				: sb_s[LANE_LAT].voxel_index;
		end
	end

	// grid memory: one write or one read per cycle while the pipeline advances
	always_ff @(posedge clk) begin
		if (en && v_s13) begin
			if (!adv_s13)
				grid_mem[addr_s13] <= '{item_s13.load_vel_x, item_s13.load_vel_y,
					item_s13.load_vel_z};
			else
				rd_s14 <= grid_mem[addr_s13];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			adv_s14    <= adv_s13;
			pos_s14[0] <= item_s13.pos_x;
			pos_s14[1] <= item_s13.pos_y;
			pos_s14[2] <= item_s13.pos_z;
			adv_s15    <= adv_s14;
			vel_s15    <= rd_s14;
			adv_s16    <= adv_s15;
			vel_s16    <= vel_s15;
		end
	end

	// per-axis advance lanes
	nga_advance_lane u_adv_x (.clk, .en, .pos(pos_s14[0]), .vel(rd_s14.vx),
		.step(time_step_q), .new_pos(np_c[0]));
	nga_advance_lane u_adv_y (.clk, .en, .pos(pos_s14[1]), .vel(rd_s14.vy),
		.step(time_step_q), .new_pos(np_c[1]));
	nga_advance_lane u_adv_z (.clk, .en, .pos(pos_s14[2]), .vel(rd_s14.vz),
		.step(time_step_q), .new_pos(np_c[2]));

	// result transaction
	assign out_valid           = v_s16 && adv_s16;
	assign out_data.new_pos_x  = np_c[0];
	assign out_data.new_pos_y  = np_c[1];
	assign out_data.new_pos_z  = np_c[2];
	assign out_data.used_vel_x = vel_s16.vx;
	assign out_data.used_vel_y = vel_s16.vy;
	assign out_data.used_vel_z = vel_s16.vz;

	// merged indexes stay inside the grid
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		v_s13 && adv_s13 |-> i_s13 <= nm1_c[0] && j_s13 <= nm1_c[1] && k_s13 <= nm1_c[2])
		else $error("grid index out of range");

	// only a held result may stall the input side
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid && out_stall)
		else $error("input stalled without a held result");

	// a load never reaches the output as a result
	a_load_silent: assert property (@(posedge clk) disable iff (!arst_n)
		en && v_s15 && !adv_s15 |=> !out_valid)
		else $error("load produced a result");

endmodule

// ===== tb/sv/nearest_grid_velocity_advect_unit_test.sv =====
// self-checking testbench for the nearest grid velocity advect unit
module nearest_grid_velocity_advect_unit_test;
	import nga_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int LATENCY = 16;
	localparam int WATCHDOG_LIMIT = 20000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	out_item_t out_data;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;

	nearest_grid_velocity_advect_unit dut (.*);

	always #5 clk = ~clk;

	// predictor state
	vel_t voxel_vel [DEPTH];
	logic [30:0] step_q;
	logic signed [31:0] low_bound [3];
	logic signed [31:0] high_bound [3];

	// voxels that a queued load writes, so no advect reads an unwritten one
	bit voxel_written [DEPTH];
	int queued_count = 0;

	in_item_t pending_items [$];
	out_item_t expected_results [$];
	int mismatch_count = 0;
	int idle_pct = 23;
	bit sink_hold = 1'b0;
	bit hold_start = 1'b0;
	bit in_fire = 1'b0;
	int quiet_cycles = 0;

	// nearest index along one axis, half away from zero, clamped
	function automatic int nearest_index(longint p, longint lo, longint hi, int n);
		longint den, num;
		longint unsigned an, ad, q;
		den = hi - lo;
		num = (p - lo) * longint'(n - 1);
		if (den == 0) return 0;
		if ((num < 0) != (den < 0) && num != 0) begin
			an = num < 0 ? -num : num;
			ad = den < 0 ? -den : den;
			q = (2 * an + ad) / (2 * ad);
			return 0;
		end
		an = num < 0 ? -num : num;
		ad = den < 0 ? -den : den;
		q = (2 * an + ad) / (2 * ad);
		if (q > longint'(n - 1)) return n - 1;
		return int'(q);
	endfunction

	// position plus velocity times step, saturating
	function automatic logic signed [31:0] step_position(longint p, longint v);
		longint unsigned mag;
		longint d, s;
		mag = longint'(v < 0 ? -v : v) * longint'(step_q);
		d = longint'((mag + 64'd32768) >> 16);
		s = v < 0 ? p - d : p + d;
		if (s > 64'sd2147483647) s = 64'sd2147483647;
		if (s < -64'sd2147483648) s = -64'sd2147483648;
		return s[31:0];
	endfunction

	function automatic int voxel_of(in_item_t it);
		int i, j, k;
		i = nearest_index(it.pos_x, low_bound[0], high_bound[0], GRID_X);
		j = nearest_index(it.pos_y, low_bound[1], high_bound[1], GRID_Y);
		k = nearest_index(it.pos_z, low_bound[2], high_bound[2], GRID_Z);
		return (i + GRID_X * (j + GRID_Y * k)) % DEPTH;
	endfunction

	// update the grid or queue the expected advect result
	task automatic predict_transaction(in_item_t it);
		out_item_t r;
		vel_t v;
		int a;
		if (it.mode == MODE_LOAD) begin
			voxel_vel[it.voxel_index] = '{it.load_vel_x, it.load_vel_y, it.load_vel_z};
		end else begin
			a = voxel_of(it);
			v = voxel_vel[a];
			r.used_vel_x = v.vx;
			r.used_vel_y = v.vy;
			r.used_vel_z = v.vz;
			r.new_pos_x = step_position(it.pos_x, v.vx);
			r.new_pos_y = step_position(it.pos_y, v.vy);
			r.new_pos_z = step_position(it.pos_z, v.vz);
			expected_results.push_back(r);
		end
	endtask

	// driver
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || in_fire) begin
				if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct) begin
					in_data <= pending_items.pop_front();
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
			out_stall <= sink_hold || ($urandom_range(99) < idle_pct);
		end
	end

	// receiver hold-off, counted in cycles
	initial begin
		wait (hold_start);
		sink_hold = 1'b1;
		repeat (200) @(posedge clk);
		sink_hold = 1'b0;
	end

	// monitor and checker
	always @(posedge clk) begin
		out_item_t e;
		if (arst_n) begin
			in_fire <= in_valid && !in_stall;
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (in_valid && !in_stall)
				predict_transaction(in_data);
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					mismatch_count++;
					if (mismatch_count <= 10) $display("unexpected result %h", out_data);
				end else begin
					e = expected_results.pop_front();
					if (e !== out_data) begin
						mismatch_count++;
						if (mismatch_count <= 10)
							$display("result mismatch: expected %h actual %h", e, out_data);
					end
				end
			end
			if (quiet_cycles > WATCHDOG_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] val);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		if (idx == REG_TIME_STEP) step_q = val[30:0];
		else if (idx[0]) low_bound[(idx - 1) / 2] = val;
		else high_bound[(idx - 1) / 2] = val;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	task automatic drain_all;
		wait (pending_items.size() == 0 && !in_valid);
		@(posedge clk);
		wait (expected_results.size() == 0);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	function automatic in_item_t load_item(int addr, logic [31:0] vx, logic [31:0] vy,
			logic [31:0] vz);
		in_item_t it;
		it = '0;
		it.mode = MODE_LOAD;
		it.voxel_index = 12'(addr);
		it.load_vel_x = vx;
		it.load_vel_y = vy;
		it.load_vel_z = vz;
		it.pos_x = $urandom;
		it.pos_y = $urandom;
		it.pos_z = $urandom;
		return it;
	endfunction

	function automatic in_item_t advect_item(logic [31:0] px, logic [31:0] py,
			logic [31:0] pz);
		in_item_t it;
		it.mode = MODE_ADVECT;
		it.voxel_index = 12'($urandom);
		it.load_vel_x = $urandom;
		it.load_vel_y = $urandom;
		it.load_vel_z = $urandom;
		it.pos_x = px;
		it.pos_y = py;
		it.pos_z = pz;
		return it;
	endfunction

	function automatic logic [31:0] rand_word();
		case ($urandom_range(5))
			0: return 32'h7fffffff;
			1: return 32'h80000000;
			2: return $urandom_range(4095) - 2048;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [31:0] near_bound(int a);
		longint lo, hi, span;
		lo = low_bound[a];
		hi = high_bound[a];
		span = hi - lo;
		if ($urandom_range(9) == 0) return $urandom;
		return 32'(lo + (span * longint'($urandom_range(1200)) - span * 100) / 1000);
	endfunction

	// queue a load and mark its voxel written
	task automatic push_load(int addr, logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
		pending_items.push_back(load_item(addr, vx, vy, vz));
		voxel_written[addr] = 1'b1;
		queued_count++;
	endtask

	// queue an advect, preceded by a load when its voxel is still unwritten
	task automatic push_advect(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
		in_item_t it;
		int a;
		it = advect_item(px, py, pz);
		a = voxel_of(it);
		if (!voxel_written[a])
			push_load(a, rand_word(), rand_word(), rand_word());
		pending_items.push_back(it);
		queued_count++;
	endtask

	// settings: step, then bounds per axis
	task automatic apply_setting(int s);
		logic [31:0] lo, hi;
		int a;
		case (s % 4)
			0: write_reg(REG_TIME_STEP, 32'h7fffffff);
			1: write_reg(REG_TIME_STEP, 32'd0);
			default: write_reg(REG_TIME_STEP, {1'b0, 31'($urandom)});
		endcase
		for (a = 0; a < 3; a++) begin
			case (s % 5)
				0: begin lo = 32'h80000000; hi = 32'h7fffffff; end
				1: begin lo = 32'h7fffffff; hi = 32'h80000000; end
				2: begin lo = $urandom; hi = lo; end
				3: begin lo = -$urandom_range(1 << 20); hi = $urandom_range(1 << 20); end
				default: begin lo = $urandom; hi = $urandom; end
			endcase
			write_reg(3'(1 + 2 * a), lo);
			write_reg(3'(2 + 2 * a), hi);
		end
	endtask

	task automatic random_phase(int n);
		int stop;
		stop = queued_count + n;
		while (queued_count < stop) begin
			if ($urandom_range(3) == 0)
				push_load(int'($urandom_range(DEPTH - 1)), rand_word(),
					rand_word(), rand_word());
			else
				push_advect(near_bound(0), near_bound(1), near_bound(2));
		end
	endtask

	initial begin
		int s;
		step_q = TIME_STEP_RST;
		for (s = 0; s < 3; s++) begin
			low_bound[s] = LOW_RST;
			high_bound[s] = HIGH_RST;
		end
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed traffic under reset settings at full rate
		idle_pct = 0;
		push_load(0, 32'h7fffffff, 32'h80000000, 32'hffffffff);
		push_load(4095, 32'h80000000, 32'h7fffffff, 32'd1);
		push_advect(32'h7fffffff, 32'h7fffffff, 32'h7fffffff);
		push_advect(32'h80000000, 32'h80000000, 32'h80000000);
		push_advect(32'd0, 32'd0, 32'd0);
		push_advect(32'd32768, 32'd2184, 32'd2185);
		push_advect(32'hffffffff, 32'd65536, 32'd65535);
		push_advect(32'h7fff0000, 32'h80010000, 32'h00010000);
		random_phase(150);
		// receiver holds off while sender keeps offering
		hold_start = 1'b1;
		drain_all();

		// settings phases with random traffic
		idle_pct = 23;
		for (s = 0; s < 8; s++) begin
			apply_setting(s);
			if (s == 3) idle_pct = 0;
			if (s == 4) idle_pct = 23;
			push_advect(32'h7fffffff, 32'h80000000, 32'd0);
			random_phase(130);
			drain_all();
		end
		if (mismatch_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end
endmodule

// ===== nearest_grid_velocity_advect_unit.f =====
rtl/core/nga_pkg.sv
rtl/core/nga_axis_lane.sv
rtl/core/nga_advance_lane.sv
rtl/core/nearest_grid_velocity_advect_unit.sv
tb/sv/nearest_grid_velocity_advect_unit_test.sv
